[hw/rtl/ifd_pkg.sv]
// ifd_pkg: shared constants for the information frame deframer.
// Register indexes, result kinds and header field constants.
// No dependencies.
`default_nettype none

package ifd_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLAG_BYTE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADDRESS_BYTE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPE_BYTE  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STUFF_MASK   = 2'd3;

   localparam logic [7:0] FLAG_RESET    = 8'd126;
   localparam logic [7:0] ADDRESS_RESET = 8'd3;
   localparam logic [7:0] ESCAPE_RESET  = 8'd125;
   localparam logic [7:0] MASK_RESET    = 8'd32;

   // control byte carries the sequence bit at this position
   localparam int SEQ_SHIFT = 6;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

endpackage

`default_nettype wire

[hw/rtl/info_frame_deframer.sv]
// info_frame_deframer: HDLC-like byte destuffing receiver with XOR block check.
// Header hunt, payload destuffing, one-word-late data output, end verdict.
// Depends on ifd_pkg.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_rx_byte
//   rsp     | out       | rsp_valid/rsp_stall | rsp_kind, rsp_data_byte, rsp_frame_ok,
//           |           |                    | rsp_ack_sequence
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One word per cycle sustained while rsp is not stalled: an input register feeds a
// single pass of compare and XOR logic into the result register. An accepted word
// waits in the input register until the result register is free to load from it.
// reset clears phase, sequence, payload state and restores register defaults.
// A stalled result holds the pass; req_stall rises only when the input register
// is full behind it. csr_ready is always high.
`default_nettype none

module info_frame_deframer (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire  [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic       rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_frame_ok,
   output logic       rsp_ack_sequence,
   input  wire        csr_valid,
   output logic       csr_ready,
   input  wire  [ifd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire  [7:0] csr_data
);

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_ADDR    = 3'd1,
      PH_CTRL    = 3'd2,
      PH_HCHK    = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   logic [7:0] flag_ff, address_ff, escape_ff, mask_ff;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   phase_type  phase_ff, phase_in;
   logic       seq_ff, seq_in;
   logic       esc_ff, esc_in;
   logic [7:0] held_ff, held_in;
   logic       held_valid_ff, held_valid_in;
   logic [7:0] parity_ff, parity_in;

   logic       out_valid_ff, out_valid_in;
   logic       out_kind_ff, out_kind_in;
   logic [7:0] out_data_ff, out_data_in;
   logic       out_ok_ff, out_ok_in;
   logic       out_ack_ff, out_ack_in;

   logic       advance, step;
   logic [7:0] ctrl, c, payload_byte;
   logic       take_payload;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;

   assign c    = in_byte_ff;
   assign ctrl = {1'b0, seq_ff, 6'd0};

   always_comb begin
      phase_in      = phase_ff;
      seq_in        = seq_ff;
      esc_in        = esc_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      parity_in     = parity_ff;
      out_kind_in   = ifd_pkg::KIND_DATA;
      out_data_in   = 8'd0;
      out_ok_in     = 1'b0;
      out_ack_in    = 1'b0;
      out_valid_in  = 1'b0;
      take_payload  = 1'b0;
      payload_byte  = c;
      case (phase_ff)
         PH_ADDR: begin
            if (c == address_ff) phase_in = PH_CTRL;
            else if (c != flag_ff) phase_in = PH_HUNT;
         end
         PH_CTRL: begin
            if (c == ctrl) phase_in = PH_HCHK;
            else phase_in = (c == flag_ff) ? PH_ADDR : PH_HUNT;
         end
         PH_HCHK: begin
            if (c == (address_ff ^ ctrl)) begin
               phase_in      = PH_PAYLOAD;
               esc_in        = 1'b0;
               held_in       = 8'd0;
               held_valid_in = 1'b0;
               parity_in     = 8'd0;
            end else begin
               phase_in = (c == flag_ff) ? PH_ADDR : PH_HUNT;
            end
         end
         PH_PAYLOAD: begin
            if (c == flag_ff) begin
               // closing flag wins over a pending escape
               seq_in        = !seq_ff;
               out_valid_in  = 1'b1;
               out_kind_in   = ifd_pkg::KIND_END;
               out_ok_in     = (parity_ff == 8'd0) && held_valid_ff;
               out_ack_in    = !seq_ff;
               phase_in      = PH_HUNT;
               esc_in        = 1'b0;
               held_in       = 8'd0;
               held_valid_in = 1'b0;
               parity_in     = 8'd0;
            end else if (esc_ff) begin
               esc_in       = 1'b0;
               take_payload = 1'b1;
               payload_byte = c ^ mask_ff;
            end else if (c == escape_ff) begin
               esc_in = 1'b1;
            end else begin
               take_payload = 1'b1;
            end
         end
         default: begin
            phase_in = (c == flag_ff) ? PH_ADDR : PH_HUNT;
         end
      endcase
      // destuffed word goes out one word late, so BCC2 stays behind
      if (take_payload) begin
         out_valid_in  = held_valid_ff;
         out_data_in   = held_ff;
         held_in       = payload_byte;
         held_valid_in = 1'b1;
         parity_in     = parity_ff ^ payload_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff       <= ifd_pkg::FLAG_RESET;
         address_ff    <= ifd_pkg::ADDRESS_RESET;
         escape_ff     <= ifd_pkg::ESCAPE_RESET;
         mask_ff       <= ifd_pkg::MASK_RESET;
         in_valid_ff   <= 1'b0;
         in_byte_ff    <= 8'd0;
         phase_ff      <= PH_HUNT;
         seq_ff        <= 1'b0;
         esc_ff        <= 1'b0;
         held_ff       <= 8'd0;
         held_valid_ff <= 1'b0;
         parity_ff     <= 8'd0;
         out_valid_ff  <= 1'b0;
         out_kind_ff   <= ifd_pkg::KIND_DATA;
         out_data_ff   <= 8'd0;
         out_ok_ff     <= 1'b0;
         out_ack_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ifd_pkg::CSR_FLAG_BYTE:    flag_ff    <= csr_data;
               ifd_pkg::CSR_ADDRESS_BYTE: address_ff <= csr_data;
               ifd_pkg::CSR_ESCAPE_BYTE:  escape_ff  <= csr_data;
               ifd_pkg::CSR_STUFF_MASK:   mask_ff    <= csr_data;
               default: ;
            endcase
         end
         if (!req_stall) in_valid_ff <= req_valid;
         if (!req_stall && req_valid) in_byte_ff <= req_rx_byte;
         if (step) begin
            phase_ff      <= phase_in;
            seq_ff        <= seq_in;
            esc_ff        <= esc_in;
            held_ff       <= held_in;
            held_valid_ff <= held_valid_in;
            parity_ff     <= parity_in;
            out_valid_ff  <= out_valid_in;
            out_kind_ff   <= out_kind_in;
            out_data_ff   <= out_data_in;
            out_ok_ff     <= out_ok_in;
            out_ack_ff    <= out_ack_in;
         end else if (advance) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_kind_ff;
   assign rsp_data_byte    = out_data_ff;
   assign rsp_frame_ok     = out_ok_ff;
   assign rsp_ack_sequence = out_ack_ff;

`ifndef SYNTHESIS
   a_held_in_payload: assert property (@(posedge clock) disable iff (reset)
      held_valid_ff |-> phase_ff == PH_PAYLOAD)
      else $error("held word outside payload phase");

   a_esc_in_payload: assert property (@(posedge clock) disable iff (reset)
      esc_ff |-> phase_ff == PH_PAYLOAD)
      else $error("escape pending outside payload phase");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (step && out_valid_in && out_kind_in == ifd_pkg::KIND_END)
      |=> (phase_ff == PH_HUNT && !held_valid_ff && parity_ff == 8'd0))
      else $error("end of frame did not clear payload state");

   a_end_toggles_seq: assert property (@(posedge clock) disable iff (reset)
      (step && out_valid_in && out_kind_in == ifd_pkg::KIND_END)
      |=> (seq_ff != $past(seq_ff) && rsp_ack_sequence == seq_ff))
      else $error("sequence bit not toggled on end of frame");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("input stalled without a blocked result");
`endif

endmodule

`default_nettype wire
